[rtl/lpr_pkg.sv]
// Shared types, constants and helpers for the IPv4 longest prefix router.
`timescale 1ns / 1ps
package lpr_pkg;

   // Table geometry
   localparam int MAX_ROUTES     = 32;
   localparam int NUM_INTERFACES = 16;
   localparam int CNT_W          = $clog2(MAX_ROUTES + 1);

   // Field widths
   localparam int ADDR_W = 32;
   localparam int LEN_W  = 6;
   localparam int IF_W   = 4;
   localparam int TTL_W  = 8;
   localparam int ST_W   = 3;

   localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(ADDR_W);

   // Result status codes
   typedef enum logic [ST_W-1:0] {
      ST_FORWARDED   = 3'd0,
      ST_TTL_EXPIRED = 3'd1,
      ST_NO_ROUTE    = 3'd2,
      ST_ADDED       = 3'd3,
      ST_FULL        = 3'd4
   } status_type;

   // Item mode codes
   typedef enum logic {
      MODE_ADD   = 1'b0,
      MODE_ROUTE = 1'b1
   } mode_type;

   // One stored route
   typedef struct packed {
      logic [ADDR_W-1:0] prefix;
      logic [LEN_W-1:0]  len;
      logic              gw_valid;
      logic [ADDR_W-1:0] gw;
      logic [IF_W-1:0]   port;
   } route_type;

   // Lookup item traveling down the chain with its running best match
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] dst;
      logic [TTL_W-1:0]  ttl;
      logic              found;
      logic [LEN_W-1:0]  best_len;
      logic [IF_W-1:0]   port;
      logic              gw_valid;
      logic [ADDR_W-1:0] gw;
   } tok_type;

   // Network mask for a prefix length of 0 to 32
   function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
      logic [ADDR_W-1:0] m;
      if (len == '0) begin
         m = '0;
      end else begin
         m = {ADDR_W{1'b1}} << (FULL_LEN - len);
      end
      return m;
   endfunction

endpackage

[rtl/ipv4_longest_prefix_router_top.sv]
// Top level of the IPv4 longest prefix router: route cell chain and result staging.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall mode, prefix, length, next hop, if, dest, ttl
//   rsp      out        rsp_valid/rsp_stall status, out_interface, hop_addr, ttl_out
//
// An add item goes straight into the staging register; a route item walks the
// chain of MAX_ROUTES cells, one cell per cycle, and then enters that register.
// One item is in the chain or staging register at a time; the output register
// lets the next item start while a result waits. Reset is synchronous and
// empties the table. A stalled result holds in the output register.
`timescale 1ns / 1ps
module ipv4_longest_prefix_router_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic [lpr_pkg::ADDR_W-1:0]        req_prefix,
   input  logic [lpr_pkg::LEN_W-1:0]         req_pfx_len,
   input  logic                              req_has_next_hop,
   input  logic [lpr_pkg::ADDR_W-1:0]        req_next_hop_ip,
   input  logic [lpr_pkg::IF_W-1:0]          req_interface_index,
   input  logic [lpr_pkg::ADDR_W-1:0]        req_dest_addr,
   input  logic [lpr_pkg::TTL_W-1:0]         req_ttl_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lpr_pkg::ST_W-1:0]          rsp_status,
   output logic [lpr_pkg::IF_W-1:0]          rsp_out_interface,
   output logic [lpr_pkg::ADDR_W-1:0]        rsp_hop_addr,
   output logic [lpr_pkg::TTL_W-1:0]         rsp_ttl_out
);
   import lpr_pkg::*;

   logic              accept;
   logic              add_go;
   logic              full;
   route_type         new_route;
   tok_type           head_tok;
   tok_type           chain_tok [0:MAX_ROUTES];
   tok_type           end_tok;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              in_flight_ff, in_flight_in;
   logic              pend_valid_ff, pend_valid_in;
   status_type        pend_status_ff, pend_status_in;
   logic [IF_W-1:0]   pend_if_ff, pend_if_in;
   logic [ADDR_W-1:0] pend_hop_ff, pend_hop_in;
   logic [TTL_W-1:0]  pend_ttl_ff, pend_ttl_in;
   logic              pend_move;
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [IF_W-1:0]   rsp_if_ff;
   logic [ADDR_W-1:0] rsp_hop_ff;
   logic [TTL_W-1:0]  rsp_ttl_ff;

   // Accept one item when nothing is in the chain or staged
   assign req_stall = in_flight_ff || pend_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign full      = count_ff >= CNT_W'(MAX_ROUTES);
   assign add_go    = accept && (req_mode == MODE_ADD) && !full;

   // Saturate the new route's length and interface
   always_comb begin
      new_route.prefix   = req_prefix;
      new_route.len      = (req_pfx_len > FULL_LEN) ? FULL_LEN : req_pfx_len;
      new_route.gw_valid = req_has_next_hop;
      new_route.gw       = req_has_next_hop ? req_next_hop_ip : '0;
      new_route.port     = (32'(req_interface_index) >= NUM_INTERFACES)
                           ? IF_W'(NUM_INTERFACES - 1) : req_interface_index;
   end

   // Launch a lookup item into the head of the chain
   always_comb begin
      head_tok          = '0;
      head_tok.valid    = accept && (req_mode == MODE_ROUTE);
      head_tok.dst      = req_dest_addr;
      head_tok.ttl      = req_ttl_in;
   end

   assign chain_tok[0] = head_tok;

   // Row of route cells
   for (genvar k = 0; k < MAX_ROUTES; k++) begin : g_cell
      lpr_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (add_go && (count_ff == CNT_W'(k))),
         .wr_route (new_route),
         .occupied (CNT_W'(k) < count_ff),
         .up_tok   (chain_tok[k]),
         .dn_tok   (chain_tok[k+1])
      );
   end

   assign end_tok = chain_tok[MAX_ROUTES];

   // Track table fill and the item in the chain
   always_comb begin
      count_in     = add_go ? count_ff + CNT_W'(1) : count_ff;
      in_flight_in = in_flight_ff;
      if (end_tok.valid) begin
         in_flight_in = 1'b0;
      end
      if (accept && (req_mode == MODE_ROUTE)) begin
         in_flight_in = 1'b1;
      end
   end

   // Stage the result of an add or of a finished lookup
   assign pend_move = pend_valid_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      pend_valid_in  = pend_valid_ff && !pend_move;
      pend_status_in = pend_status_ff;
      pend_if_in     = pend_if_ff;
      pend_hop_in    = pend_hop_ff;
      pend_ttl_in    = pend_ttl_ff;
      if (accept && (req_mode == MODE_ADD)) begin
         pend_valid_in  = 1'b1;
         pend_status_in = full ? ST_FULL : ST_ADDED;
         pend_if_in     = '0;
         pend_hop_in    = '0;
         pend_ttl_in    = '0;
      end else if (end_tok.valid) begin
         pend_valid_in = 1'b1;
         pend_if_in    = '0;
         pend_hop_in   = '0;
         pend_ttl_in   = '0;
         if (end_tok.ttl <= TTL_W'(1)) begin
            pend_status_in = ST_TTL_EXPIRED;
         end else if (!end_tok.found) begin
            pend_status_in = ST_NO_ROUTE;
         end else begin
            pend_status_in = ST_FORWARDED;
            pend_if_in     = end_tok.port;
            pend_hop_in    = end_tok.gw_valid ? end_tok.gw : end_tok.dst;
            pend_ttl_in    = end_tok.ttl - TTL_W'(1);
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         in_flight_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         in_flight_ff  <= in_flight_in;
         pend_valid_ff <= pend_valid_in;
         if (pend_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: staging and output
   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_if_ff     <= pend_if_in;
      pend_hop_ff    <= pend_hop_in;
      pend_ttl_ff    <= pend_ttl_in;
      if (pend_move) begin
         rsp_status_ff <= pend_status_ff;
         rsp_if_ff     <= pend_if_ff;
         rsp_hop_ff    <= pend_hop_ff;
         rsp_ttl_ff    <= pend_ttl_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_interface = rsp_if_ff;
   assign rsp_hop_addr      = rsp_hop_ff;
   assign rsp_ttl_out       = rsp_ttl_ff;

endmodule

[rtl/lpr_cell.sv]
// One route cell: holds a route and updates the best match of a passing item.
`timescale 1ns / 1ps
module lpr_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  lpr_pkg::route_type wr_route,
   input  logic               occupied,
   input  lpr_pkg::tok_type   up_tok,
   output lpr_pkg::tok_type   dn_tok
);
   import lpr_pkg::*;

   route_type         rt_ff;
   tok_type           tok_ff;
   tok_type           tok_in;
   logic [ADDR_W-1:0] mask;
   logic              hit;

   // Store the route when this cell is the next free slot
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rt_ff <= wr_route;
      end
   end

   // Compare; only a strictly longer prefix replaces an earlier match
   always_comb begin
      mask   = len_mask(rt_ff.len);
      hit    = up_tok.valid && occupied
               && (((rt_ff.prefix ^ up_tok.dst) & mask) == '0)
               && (!up_tok.found || (rt_ff.len > up_tok.best_len));
      tok_in = up_tok;
      if (hit) begin
         tok_in.found    = 1'b1;
         tok_in.best_len = rt_ff.len;
         tok_in.port     = rt_ff.port;
         tok_in.gw_valid = rt_ff.gw_valid;
         tok_in.gw       = rt_ff.gw;
      end
   end

   // Hand the item to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign dn_tok = tok_ff;

endmodule
